@@ rtl/modbus_rtu_crc_framer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Modbus RTU CRC framer assertion macros
// Shared concurrent assertion forms. Each macro expects clk and rst to be
// visible in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_CRC_FRAMER_TOP_ASSERT_SVH
`define MODBUS_RTU_CRC_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MRCF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mrcf_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU CRC framer package
// Result codes, bundle types and the byte-wide CRC-16 update shared by the
// framer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrcf_pkg;

  // Reflected CRC-16 as used by Modbus RTU.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // At most three results come from one input byte.
  localparam int MaxResults = 3;
  localparam int ResCntW    = $clog2(MaxResults + 1);

  typedef enum logic {
    DIR_APPEND = 1'b0,
    DIR_CHECK  = 1'b1
  } dir_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_CRC     = 2'd1,
    KIND_VERDICT = 2'd2
  } item_kind_t;

  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_BAD   = 2'd1,
    VERDICT_SHORT = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] out_byte;
    item_kind_t item_kind;
    verdict_t   verdict;
  } result_t;

  // All results caused by one input byte, entry 0 delivered first.
  typedef struct packed {
    logic [ResCntW-1:0]          count;
    result_t [MaxResults-1:0]    res;
  } bundle_t;

  // One byte through the CRC, LSB first, eight shift steps unrolled.
  function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mrcf_core.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU CRC framer core
// Holds the frame state (running CRC, held byte pair, direction) and turns
// each accepted byte into a bundle of up to three results in one pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "modbus_rtu_crc_framer_top_assert.svh"

module mrcf_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_fire,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  output mrcf_pkg::bundle_t       bundle,
  output logic                    push
);
  import mrcf_pkg::*;

  dir_t        direction;
  logic [15:0] crc_acc;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [1:0]  held_count;

  logic [15:0] crc_acc_next;
  logic [7:0]  held0_next;
  logic [7:0]  held1_next;
  logic [1:0]  held_count_next;
  logic [7:0]  crc_byte;
  logic [15:0] crc_upd;
  logic        slot;
  verdict_t    verd;
  logic        frame_clear;

  // The CRC sees the incoming byte in append mode and the released byte in
  // check mode.
  assign crc_byte = (direction == DIR_CHECK) ? held0 : in_byte;
  assign crc_upd  = crc_update(crc_acc, crc_byte);

  // Next frame state and the results for this byte.
  always_comb begin
    crc_acc_next    = crc_acc;
    held0_next      = held0;
    held1_next      = held1;
    held_count_next = held_count;
    bundle          = '0;
    slot            = 1'b0;
    verd            = VERDICT_OK;
    unique case (direction)
      DIR_APPEND: begin
        crc_acc_next  = crc_upd;
        bundle.res[0] = '{out_byte: in_byte, item_kind: KIND_PAYLOAD, verdict: VERDICT_OK};
        bundle.count  = ResCntW'(1);
        if (in_last) begin
          bundle.res[1] = '{out_byte: crc_upd[7:0], item_kind: KIND_CRC,
                            verdict: VERDICT_OK};
          bundle.res[2] = '{out_byte: crc_upd[15:8], item_kind: KIND_CRC,
                            verdict: VERDICT_OK};
          bundle.count  = ResCntW'(3);
        end
      end
      DIR_CHECK: begin
        // With a full pair held, the older byte leaves as payload.
        if (held_count[1]) begin
          crc_acc_next  = crc_upd;
          bundle.res[0] = '{out_byte: held0, item_kind: KIND_PAYLOAD,
                            verdict: VERDICT_OK};
          bundle.count  = ResCntW'(1);
          slot          = 1'b1;
          held0_next    = held1;
          held1_next    = in_byte;
        end else if (held_count[0]) begin
          held1_next      = in_byte;
          held_count_next = 2'd2;
        end else begin
          held0_next      = in_byte;
          held_count_next = 2'd1;
        end
        if (in_last) begin
          if (!held_count_next[1]) begin
            verd = VERDICT_SHORT;
          end else if ({held1_next, held0_next} == crc_acc_next) begin
            verd = VERDICT_OK;
          end else begin
            verd = VERDICT_BAD;
          end
          bundle.res[{1'b0, slot}] = '{out_byte: 8'h00, item_kind: KIND_VERDICT,
                                       verdict: verd};
          bundle.count     = {{(ResCntW-1){1'b0}}, slot} + ResCntW'(1);
        end
      end
      default: begin
      end
    endcase
    // The frame ends here in either direction.
    if (in_last) begin
      crc_acc_next    = CrcInit;
      held0_next      = 8'h00;
      held1_next      = 8'h00;
      held_count_next = 2'd0;
    end
  end

  assign push = in_fire && (bundle.count != '0);

  // State registers; a register write aborts the frame in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= DIR_APPEND;
      crc_acc    <= CrcInit;
      held0      <= 8'h00;
      held1      <= 8'h00;
      held_count <= 2'd0;
    end else if (cfg_we) begin
      direction  <= dir_t'(cfg_wdata);
      crc_acc    <= CrcInit;
      held0      <= 8'h00;
      held1      <= 8'h00;
      held_count <= 2'd0;
    end else if (in_fire) begin
      crc_acc    <= crc_acc_next;
      held0      <= held0_next;
      held1      <= held1_next;
      held_count <= held_count_next;
    end
  end

  // The frame state is back at its start values.
  assign frame_clear = (held_count == 2'd0) && (crc_acc == CrcInit);

  // Checks on the frame state.
  `MRCF_ASSERT_IMPL(a_held_count_range, 1'b1, held_count != 2'd3, "held_count above two")
  `MRCF_ASSERT_NEXT(a_end_clears, in_fire && in_last && !cfg_we, frame_clear, "frame state kept")
  `MRCF_ASSERT_IMPL(a_last_gives_result, in_fire && in_last, push, "last byte produced no result")

endmodule

`default_nettype wire

@@ rtl/mrcf_serializer.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU CRC framer result serializer
// Two-slot bundle queue that hands the results of each byte to the output
// channel one transfer at a time and marks the last one of each bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "modbus_rtu_crc_framer_top_assert.svh"

module mrcf_serializer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire mrcf_pkg::bundle_t  bundle,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mrcf_pkg::result_t       out_res,
  output logic                    out_last
);
  import mrcf_pkg::*;

  bundle_t            slot0;
  bundle_t            slot1;
  logic               valid0;
  logic               valid1;
  logic [ResCntW-1:0] idx;
  logic               out_fire;
  logic               pop;

  // The head slot drives the output; the second slot absorbs a stall.
  assign out_valid = valid0;
  assign out_res   = slot0.res[idx];
  assign out_last  = (idx == (slot0.count - ResCntW'(1)));
  assign out_fire  = valid0 && out_ready;
  assign pop       = out_fire && out_last;
  assign in_ready  = !valid1;

  // Result index within the head bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_fire) begin
      idx <= out_last ? '0 : idx + ResCntW'(1);
    end
  end

  // Slot valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else begin
      if (pop) begin
        valid0 <= valid1 || push;
        valid1 <= 1'b0;
      end else if (push) begin
        if (valid0) begin
          valid1 <= 1'b1;
        end else begin
          valid0 <= 1'b1;
        end
      end
    end
  end

  // Slot payloads.
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= valid1 ? slot1 : bundle;
    end else if (push) begin
      if (valid0) begin
        slot1 <= bundle;
      end else begin
        slot0 <= bundle;
      end
    end
  end

  // Checks on the queue.
  `MRCF_ASSERT_IMPL(a_slot_order, valid1, valid0, "second slot filled while head is empty")
  `MRCF_ASSERT_IMPL(a_push_has_room, push, !valid1, "bundle pushed into a full queue")
  `MRCF_ASSERT_IMPL(a_idx_in_bundle, valid0, idx < slot0.count, "result index past bundle end")

endmodule

`default_nettype wire

@@ rtl/modbus_rtu_crc_framer_top.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU CRC framer
// Appends or checks the Modbus RTU CRC-16 on a byte stream, one frame per
// tlast-delimited run.
//
//   Channel  Role        Content
//   s_axis   input       tdata: data_byte; tlast: frame_last
//   m_axis   output      tdata: out_byte; tuser: item_kind, verdict; tlast: run_last
//   cfg      write-only  cfg_wdata: direction (0 append, 1 check)
//
// One byte can be accepted per cycle while the second queue slot is free; the
// CRC update is an unrolled eight-step shift in front of a two-slot result
// queue whose registered head slot drives the output. Each byte yields zero to
// three output transfers, one per cycle while m_axis_tready is high.
// s_axis_tready drops while the second queue slot is full: when the head
// bundle has several results or m_axis_tready is low.
// Synchronous reset clears the frame state, selects append and empties the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_crc_framer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,      // direction
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,   // frame_last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [3:0]      m_axis_tuser,   // [1:0] item_kind, [3:2] verdict
  output logic            m_axis_tlast    // run_last
);
  import mrcf_pkg::*;

  logic    in_fire;
  logic    push;
  bundle_t bundle;
  result_t out_res;

  // Input transfer.
  assign in_fire = s_axis_tvalid && s_axis_tready;

  mrcf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .bundle    (bundle),
    .push      (push)
  );

  mrcf_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .bundle    (bundle),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .out_last  (m_axis_tlast)
  );

  // Output packing.
  assign m_axis_tdata = out_res.out_byte;
  assign m_axis_tuser = {out_res.verdict, out_res.item_kind};

endmodule

`default_nettype wire
